// ===== rtl/lru_pkg.sv =====
// Shared types, sizes and helper functions for the LRU page replacement block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lru_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int STAMP_BITS  = 32;
    localparam int COUNT_BITS  = 32;
    localparam int PAGE_BITS   = 8;
    localparam int CFG_BITS    = 4;
    localparam int SLOT_BITS   = 3;
    localparam int IDX_BITS    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FILL_BITS   = $clog2(MAX_FRAMES + 1);

    localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(8);

    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [FILL_BITS-1:0]  t_fill;
    typedef logic [CFG_BITS-1:0]   t_cfg;
    typedef logic [SLOT_BITS-1:0]  t_slot;

    // One frame entry as held in the frame memory.
    typedef struct packed {
        t_page  page;
        t_stamp stamp;
    } t_frame;

    // Result of the shared compare unit.
    typedef struct packed {
        logic page_eq;
        logic stamp_lt;
    } t_cmp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // Effective frame limit: zero acts as one, anything too large is clipped.
    function automatic t_fill frame_limit(input t_cfg cfg);
        t_fill lim;
        if (cfg == '0) begin
            lim = FILL_BITS'(1);
        end else if (32'(cfg) > MAX_FRAMES) begin
            lim = FILL_BITS'(MAX_FRAMES);
        end else begin
            lim = FILL_BITS'(cfg);
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lru_if.sv =====
// Request and response channel interfaces of the LRU page replacement block.
// Depends on lru_pkg for the payload types.
`default_nettype none

interface lru_req_if;
    import lru_pkg::*;

    logic  valid;
    logic  ready;
    t_page page;
    logic  restart;

    modport source (output valid, output page, output restart, input ready);
    modport sink   (input valid, input page, input restart, output ready);
endinterface

interface lru_rsp_if;
    import lru_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    t_slot  slot;
    logic   evicted;
    t_page  evicted_page;
    t_count fault_count;
    t_count hit_count;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_page, output fault_count, output hit_count,
                    input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_page, input fault_count, input hit_count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: sequencer, counters, result register.
// Depends on lru_pkg, lru_if, lru_frame_mem and lru_cmp_unit.
`default_nettype none

// The block takes one page reference per request and answers with one result:
// whether the page was resident, the frame slot that now holds it, the page it
// displaced (if any) and saturating fault and hit totals. Frames live in a small
// memory that holds a page and its last-use stamp. After a request is accepted
// the sequencer reads the filled frames one per cycle through the single read
// port and runs each through one shared compare unit, which checks for a page
// match and compares its stamp against the oldest stamp so far among the frames
// allowed for replacement. A request is accepted, then scanned (one read per
// filled frame, then the last frame comes back through the memory read register
// and is compared, then a check sees that no read is still outstanding), and
// then the frame is written back and the result loaded. A hit stops the reads
// early. The input is not ready from the accept until the write-back. The
// result, totals included, sits in an output register, so the next request is
// accepted while an earlier result still waits to be taken; the write-back of
// that next request then waits until the earlier result is taken. A set
// restart bit clears the fill count, the step counter and the totals before
// the page is handled. The frame limit register is written through
// i_cfg_we/i_cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce; zero acts as one and values above
// eight act as eight.
module lru_page_replacement (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire lru_pkg::t_cfg i_cfg_wdata,
    lru_req_if.sink            i_req,
    lru_rsp_if.source          o_rsp
);
    import lru_pkg::*;

    // Control state.
    t_state r_state, n_state;
    t_cfg   r_frames_in_use;
    t_fill  r_filled, n_filled;
    t_stamp r_step, n_step;
    t_count r_faults, n_faults;
    t_count r_hits, n_hits;

    // Scan state.
    t_fill  r_rd_idx, n_rd_idx;
    logic   r_rd_vld;
    t_idx   r_cmp_idx;
    logic   r_found, n_found;
    t_idx   r_hit_idx, n_hit_idx;
    logic   r_best_set, n_best_set;
    t_idx   r_best_idx, n_best_idx;
    t_stamp r_best_stamp, n_best_stamp;
    t_page  r_best_page, n_best_page;
    t_page  r_page;

    // Result register.
    logic   r_out_valid, n_out_valid;
    logic   r_out_hit;
    t_slot  r_out_slot;
    logic   r_out_evicted;
    t_page  r_out_evicted_page;
    t_count r_out_faults;
    t_count r_out_hits;

    // Sequencer outputs.
    logic   req_ready;
    logic   rd_en;
    logic   upd_go;
    logic   scan_done;

    logic   req_accept;
    t_fill  lim;
    t_frame rd_data;
    t_cmp   cmp;
    t_idx   upd_slot;
    logic   upd_evict;
    logic   upd_fill;

    assign req_accept = i_req.valid && req_ready;
    assign lim        = frame_limit(r_frames_in_use);

    lru_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (upd_go),
        .i_waddr (upd_slot),
        .i_wdata ({r_page, r_step}),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_BITS-1:0]),
        .o_rdata (rd_data)
    );

    lru_cmp_unit u_cmp (
        .i_entry      (rd_data),
        .i_page       (r_page),
        .i_best_stamp (r_best_stamp),
        .o_cmp        (cmp)
    );

    // Reads stop once a hit is known or every filled frame has been issued.
    assign scan_done = !rd_en && !r_rd_vld;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (upd_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        upd_go    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                req_ready = 1'b1;
            end
            ST_SCAN: begin
                rd_en = !r_found && (r_rd_idx < r_filled);
            end
            ST_UPDATE: begin
                upd_go = !r_out_valid || o_rsp.ready;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Where the referenced page goes: the hit frame, the next empty frame, or
    // the oldest frame among those the limit allows.
    always_comb begin
        upd_fill  = !r_found && (r_filled < lim);
        upd_evict = !r_found && !upd_fill;
        if (r_found) begin
            upd_slot = r_hit_idx;
        end else if (upd_fill) begin
            upd_slot = r_filled[IDX_BITS-1:0];
        end else begin
            upd_slot = r_best_idx;
        end
    end

    // Datapath next values.
    always_comb begin
        n_filled     = r_filled;
        n_step       = r_step;
        n_faults     = r_faults;
        n_hits       = r_hits;
        n_rd_idx     = r_rd_idx;
        n_found      = r_found;
        n_hit_idx    = r_hit_idx;
        n_best_set   = r_best_set;
        n_best_idx   = r_best_idx;
        n_best_stamp = r_best_stamp;
        n_best_page  = r_best_page;
        n_out_valid  = r_out_valid;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        if (req_accept) begin
            n_rd_idx   = '0;
            n_found    = 1'b0;
            n_best_set = 1'b0;
            if (i_req.restart) begin
                n_filled = '0;
                n_step   = '0;
                n_faults = '0;
                n_hits   = '0;
            end
        end

        if (rd_en) begin
            n_rd_idx = r_rd_idx + FILL_BITS'(1);
        end

        // Compare the frame that came back from the memory this cycle.
        if (r_rd_vld) begin
            if (cmp.page_eq && !r_found) begin
                n_found   = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if ((FILL_BITS'(r_cmp_idx) < lim) && (!r_best_set || cmp.stamp_lt)) begin
                n_best_set   = 1'b1;
                n_best_idx   = r_cmp_idx;
                n_best_stamp = rd_data.stamp;
                n_best_page  = rd_data.page;
            end
        end

        if (upd_go) begin
            n_out_valid = 1'b1;
            if (upd_fill) begin
                n_filled = r_filled + FILL_BITS'(1);
            end
            if (r_found) begin
                if (r_hits != '1) begin
                    n_hits = r_hits + COUNT_BITS'(1);
                end
            end else begin
                if (r_faults != '1) begin
                    n_faults = r_faults + COUNT_BITS'(1);
                end
            end
            if (r_step != '1) begin
                n_step = r_step + STAMP_BITS'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_frames_in_use <= FRAMES_RESET;
            r_filled        <= '0;
            r_step          <= '0;
            r_faults        <= '0;
            r_hits          <= '0;
            r_rd_idx        <= '0;
            r_rd_vld        <= 1'b0;
            r_found         <= 1'b0;
            r_best_set      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_step      <= n_step;
            r_faults    <= n_faults;
            r_hits      <= n_hits;
            r_rd_idx    <= n_rd_idx;
            r_rd_vld    <= rd_en;
            r_found     <= n_found;
            r_best_set  <= n_best_set;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmp_idx    <= r_rd_idx[IDX_BITS-1:0];
        r_hit_idx    <= n_hit_idx;
        r_best_idx   <= n_best_idx;
        r_best_stamp <= n_best_stamp;
        r_best_page  <= n_best_page;
        if (req_accept) begin
            r_page <= i_req.page;
        end
        // The totals are captured with the rest of the result, so a restart on
        // the next request cannot disturb a result that is still waiting.
        if (upd_go) begin
            r_out_hit          <= r_found;
            r_out_slot         <= SLOT_BITS'(upd_slot);
            r_out_evicted      <= upd_evict;
            r_out_evicted_page <= upd_evict ? r_best_page : '0;
            r_out_faults       <= n_faults;
            r_out_hits         <= n_hits;
        end
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.slot         = r_out_slot;
    assign o_rsp.evicted      = r_out_evicted;
    assign o_rsp.evicted_page = r_out_evicted_page;
    assign o_rsp.fault_count  = r_out_faults;
    assign o_rsp.hit_count    = r_out_hits;

    // The fill count never passes the number of frames in the memory.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= MAX_FRAMES)
        else $error("frame fill count above frame count");

    // A memory read is only ever issued for a filled frame.
    a_read_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_idx < r_filled))
        else $error("read issued beyond filled frames");

    // Finishing an update always leaves a result waiting in the output register.
    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> (r_out_valid && r_state == ST_IDLE))
        else $error("update did not produce a result");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_evicted))
        else $error("hit reported together with eviction");

endmodule

`default_nettype wire

// ===== rtl/lru_frame_mem.sv =====
// Frame memory: page and last-use stamp per frame, one write and one read port.
// Depends on lru_pkg; read data is registered.
`default_nettype none

module lru_frame_mem (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire lru_pkg::t_idx   i_waddr,
    input  wire lru_pkg::t_frame i_wdata,
    input  wire logic           i_re,
    input  wire lru_pkg::t_idx   i_raddr,
    output lru_pkg::t_frame      o_rdata
);
    import lru_pkg::*;

    t_frame r_mem [MAX_FRAMES];
    t_frame r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lru_cmp_unit.sv =====
// Shared compare unit: page match and stamp ordering against the running best.
// Depends on lru_pkg.
`default_nettype none

module lru_cmp_unit (
    input  wire lru_pkg::t_frame i_entry,
    input  wire lru_pkg::t_page  i_page,
    input  wire lru_pkg::t_stamp i_best_stamp,
    output lru_pkg::t_cmp        o_cmp
);
    import lru_pkg::*;

    always_comb begin
        o_cmp.page_eq  = (i_entry.page == i_page);
        o_cmp.stamp_lt = (i_entry.stamp < i_best_stamp);
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for lru_page_replacement: clocked driver, monitor and LRU predictor.
// Depends on lru_pkg and the request/response interfaces in lru_if.sv.
`default_nettype none

module tb;
    import lru_pkg::*;

    // One page reference as it waits in the driver's queue.
    typedef struct packed {
        t_page page;
        logic  restart;
    } t_page_ref;

    // Everything the block reports for one reference.
    typedef struct packed {
        logic   hit;
        t_slot  slot;
        logic   evicted;
        t_page  evicted_page;
        t_count fault_count;
        t_count hit_count;
    } t_lru_result;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PERCENT = 19;
    // The response side holds off once, for a long stretch, after this many requests.
    localparam int HOLD_AFTER   = 250;
    localparam int HOLD_CYCLES  = 300;
    // Neither side idles while the request count is inside this window.
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 650;
    localparam int RANDOM_PER_SETTING = 52;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    t_cfg cfg_wdata = '0;

    lru_req_if req_ch ();
    lru_rsp_if rsp_ch ();

    lru_page_replacement uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Requests waiting to be offered, and results the block still owes us.
    t_page_ref   pending_refs[$];
    t_lru_result expected_results[$];

    int refs_taken = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    wire quiet = (refs_taken >= QUIET_FROM) && (refs_taken < QUIET_TO);

    // Shadow of the block's state, advanced once per accepted request.
    t_cfg   limit_cfg = FRAMES_RESET;
    t_page  frame_pages[MAX_FRAMES];
    t_stamp frame_stamps[MAX_FRAMES];
    int     frames_filled = 0;
    t_stamp step_now = '0;
    t_count faults_seen = '0;
    t_count hits_seen = '0;

    // The frame limit register reads zero as one and clips anything above the frame count.
    function automatic int usable_frames(input t_cfg cfg);
        if (cfg == '0) begin
            return 1;
        end
        return (int'(cfg) > MAX_FRAMES) ? MAX_FRAMES : int'(cfg);
    endfunction

    // Applies one reference to the shadow state and returns what the block must answer.
    function automatic t_lru_result lru_lookup(input t_page page, input logic restart);
        t_lru_result res;
        int lim;
        int sel;
        bit found;
        res = '0;
        sel = 0;
        found = 1'b0;
        if (restart) begin
            frames_filled = 0;
            step_now = '0;
            faults_seen = '0;
            hits_seen = '0;
        end
        lim = usable_frames(limit_cfg);

        // A hit may land in any filled frame, even above a lowered limit.
        for (int j = 0; j < frames_filled; j++) begin
            if (!found && frame_pages[j] == page) begin
                found = 1'b1;
                sel = j;
            end
        end

        if (found) begin
            frame_stamps[sel] = step_now;
            if (hits_seen != '1) begin
                hits_seen++;
            end
        end else begin
            if (frames_filled < lim) begin
                sel = frames_filled;
                frames_filled++;
            end else begin
                // Oldest stamp among the first lim frames; strict compare keeps the lowest index.
                for (int j = 1; j < lim; j++) begin
                    if (frame_stamps[j] < frame_stamps[sel]) begin
                        sel = j;
                    end
                end
                res.evicted = 1'b1;
                res.evicted_page = frame_pages[sel];
            end
            frame_pages[sel] = page;
            frame_stamps[sel] = step_now;
            if (faults_seen != '1) begin
                faults_seen++;
            end
        end

        if (step_now != '1) begin
            step_now++;
        end

        res.hit = found;
        res.slot = t_slot'(sel);
        res.fault_count = faults_seen;
        res.hit_count = hits_seen;
        return res;
    endfunction

    // Driver: on acceptance the reference goes through the predictor; a free slot takes
    // the next queued reference unless this cycle is drawn as an idle one.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.page <= '0;
            req_ch.restart <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results = {expected_results,
                                    lru_lookup(req_ch.page, req_ch.restart)};
                refs_taken <= refs_taken + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_refs.size() != 0
                        && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                    req_ch.valid <= 1'b1;
                    req_ch.page <= pending_refs[0].page;
                    req_ch.restart <= pending_refs[0].restart;
                    void'(pending_refs.pop_front());
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off on the response side is timed here, apart from the monitor.
    // While it runs the sender keeps offering, so the output register fills and the
    // block stops taking requests.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && refs_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge clk) begin : rsp_monitor
        t_lru_result want;
        t_lru_result got;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted, rsp_ch.evicted_page,
                       rsp_ch.fault_count, rsp_ch.hit_count};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("ERROR: result with nothing expected: hit=%0b slot=%0d",
                                 got.hit, got.slot);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot
                            || got.evicted !== want.evicted
                            || got.evicted_page !== want.evicted_page
                            || got.fault_count !== want.fault_count
                            || got.hit_count !== want.hit_count) begin
                        if (mismatches < 10) begin
                            $display("ERROR: want hit %0b slot %0d ev %0b pg %h f %0d h %0d",
                                     want.hit, want.slot, want.evicted, want.evicted_page,
                                     want.fault_count, want.hit_count);
                            $display("       got  hit %0b slot %0d ev %0b pg %h f %0d h %0d",
                                     got.hit, got.slot, got.evicted, got.evicted_page,
                                     got.fault_count, got.hit_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // A stuck handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_ref(input t_page page, input logic restart = 1'b0);
        t_page_ref item;
        item.page = page;
        item.restart = restart;
        pending_refs = {pending_refs, item};
    endtask

    // Returns once every queued request went out and every result came back.
    // Each request yields exactly one result, so the block is idle by then.
    task automatic wait_drained();
        while (pending_refs.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_limit(input t_cfg value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        limit_cfg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly references from a small working set of up to three pages more than the
    // frame limit, so hits and evictions both come often; the rest are stray pages.
    // Either kind may carry the odd restart. The working set drifts slowly.
    task automatic queue_random_refs(input int count);
        t_page pool[$];
        int pool_size;
        int roll;
        pool_size = usable_frames(limit_cfg) + $urandom_range(3);
        for (int k = 0; k < pool_size; k++) begin
            pool = {pool, t_page'($urandom)};
        end
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                pool[$urandom_range(pool_size - 1)] = t_page'($urandom);
            end
            if (roll < 78) begin
                queue_ref(pool[$urandom_range(pool_size - 1)], $urandom_range(99) < 2);
            end else begin
                queue_ref(t_page'($urandom), $urandom_range(99) < 4);
            end
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.page = '0;
        req_ch.restart = 1'b0;
        rsp_ch.ready = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limit of eight: fill every frame with all-zero, all-one, alternating
        // and single-bit pages, refresh two of them, then force an eviction of the
        // least recently used one.
        queue_ref(8'h00);
        queue_ref(8'hFF);
        queue_ref(8'h55);
        queue_ref(8'hAA);
        queue_ref(8'h01);
        queue_ref(8'h02);
        queue_ref(8'h04);
        queue_ref(8'h08);
        queue_ref(8'h00);
        queue_ref(8'h55);
        queue_ref(8'h10);
        wait_drained();

        // Limit lowered under a full set of frames: a page in a high frame still
        // hits, a miss only replaces within the first three, nothing new is filled until a restart.
        write_limit(t_cfg'(3));
        queue_ref(8'h08);
        queue_ref(8'h20);
        queue_ref(8'h7F);
        queue_ref(8'h80, 1'b1);
        queue_ref(8'h80);
        wait_drained();

        // A limit of zero behaves as a single frame.
        write_limit(t_cfg'(0));
        queue_ref(8'h03, 1'b1);
        queue_ref(8'h03);
        queue_ref(8'h07);
        wait_drained();

        // The largest register value is clipped to the full frame count.
        write_limit(t_cfg'(15));
        queue_ref(8'hFE);
        queue_ref(8'h01);
        queue_ref(8'hFE);
        wait_drained();

        // Random traffic under every register value, in an order that mixes raising
        // and lowering the limit while frames stay filled.
        for (int i = 0; i < 16; i++) begin
            write_limit(t_cfg'((i * 7 + 3) % 16));
            queue_random_refs(RANDOM_PER_SETTING);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
